@@ src/lmsd_pkg.sv @@
// Shared types and constants for the bicolor LED matrix scan driver.
`timescale 1ns / 1ps
`default_nettype none
package lmsd_pkg;

  // Default geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 7;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int PCOL_W   = 7;
  localparam int PROW_W   = 4;
  localparam int COLOR_W  = 2;
  localparam int RSEL_W   = 3;
  localparam int TICKS_W  = 16;
  localparam int CFG_IDX_W = 4;

  // Reset values of the timing registers
  localparam logic [TICKS_W-1:0] ON_TICKS_RST  = 16'd100;
  localparam logic [TICKS_W-1:0] OFF_TICKS_RST = 16'd0;

  // Input item modes
  localparam logic [MODE_W-1:0] MODE_PIXEL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

  // Pixel colors
  localparam logic [COLOR_W-1:0] COLOR_GREEN  = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_RED    = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_ORANGE = 2'd2;
  localparam logic [COLOR_W-1:0] COLOR_BLANK  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ON_TICKS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TICKS = 4'd1;

  // Command and result queue depths
  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_op_t;

  typedef enum logic [1:0] {
    PH_SHIFT = 2'd0,
    PH_ON    = 2'd1,
    PH_OFF   = 2'd2
  } scan_phase_t;

  // Classified command from front to back
  typedef struct packed {
    cmd_op_t              op;
    logic [RSEL_W-1:0]    row_idx;   // store row
    logic [PCOL_W-1:0]    col_idx;   // zero-based column
    logic [COLOR_W-1:0]   color;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic              green_data;
    logic              red_data;
    logic              shift_clock;
    logic [RSEL_W-1:0] row_select;
  } res_t;

endpackage
`default_nettype wire

@@ src/lmsd_front.sv @@
// Front end: classifies input items and queues commands for the back end.
`timescale 1ns / 1ps
`default_nettype none
module lmsd_front #(
  parameter int COLUMNS = lmsd_pkg::DEF_COLUMNS,
  parameter int ROWS    = lmsd_pkg::DEF_ROWS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_push,
  output logic                              in_full,
  input  wire logic [lmsd_pkg::MODE_W-1:0]  in_mode,
  input  wire logic [lmsd_pkg::PCOL_W-1:0]  in_pixel_column,
  input  wire logic [lmsd_pkg::PROW_W-1:0]  in_pixel_row,
  input  wire logic [lmsd_pkg::COLOR_W-1:0] in_pixel_color,
  output logic                              cmd_valid,
  output lmsd_pkg::cmd_t                    cmd,
  input  wire logic                         cmd_pop
);
  import lmsd_pkg::*;

  localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int NW = $clog2(CMDQ_DEPTH + 1);

  cmd_t           entry_r [CMDQ_DEPTH];
  logic [PW-1:0]  wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [NW-1:0]  count_r, count_nxt;
  cmd_t           new_cmd;
  logic           keep;
  logic           do_push, do_pop;
  logic           col_ok, row_ok;

  // Classify the incoming item
  always_comb begin
    col_ok = (in_pixel_column != '0) && (int'(in_pixel_column) <= COLUMNS);
    row_ok = (in_pixel_row != '0) && (int'(in_pixel_row) <= ROWS);
    new_cmd.row_idx = RSEL_W'(ROWS - int'(in_pixel_row));
    new_cmd.col_idx = in_pixel_column - PCOL_W'(1);
    new_cmd.color   = in_pixel_color;
    new_cmd.op      = CMD_TICK;
    keep            = 1'b0;
    unique case (in_mode)
      MODE_PIXEL: begin
        new_cmd.op = CMD_WRITE;
        keep       = col_ok && row_ok;
      end
      MODE_CLEAR: begin
        new_cmd.op = CMD_CLEAR;
        keep       = 1'b1;
      end
      MODE_TICK: begin
        new_cmd.op = CMD_TICK;
        keep       = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  // Command queue control
  assign in_full   = (count_r == NW'(CMDQ_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = entry_r[rptr_r];
  assign do_push   = in_push && !in_full && keep;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(CMDQ_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(CMDQ_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + NW'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wptr_r] <= new_cmd;
    end
  end

endmodule
`default_nettype wire

@@ src/lmsd_back.sv @@
// Back end: frame store, row scanner and timing registers.
`timescale 1ns / 1ps
`default_nettype none
module lmsd_back #(
  parameter int COLUMNS = lmsd_pkg::DEF_COLUMNS,
  parameter int ROWS    = lmsd_pkg::DEF_ROWS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lmsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lmsd_pkg::TICKS_W-1:0]   cfg_data,
  input  wire logic                           cmd_valid,
  input  wire lmsd_pkg::cmd_t                 cmd,
  output logic                                cmd_pop,
  output logic                                res_push,
  output lmsd_pkg::res_t                      res,
  input  wire logic                           res_full
);
  import lmsd_pkg::*;

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [COLUMNS-1:0] green_plane_r [ROWS];
  logic [COLUMNS-1:0] red_plane_r   [ROWS];
  logic [COLUMNS-1:0] green_line_r, green_line_nxt;
  logic [COLUMNS-1:0] red_line_r, red_line_nxt;
  logic [COLUMNS-1:0] green_row, red_row;
  scan_phase_t        phase_r, phase_nxt;
  logic [CW-1:0]      col_cnt_r, col_cnt_nxt;
  logic [TICKS_W-1:0] dwell_r, dwell_nxt, dwell_inc;
  logic [RSEL_W-1:0]  cur_row_r, cur_row_nxt, row_wrap;
  logic [TICKS_W-1:0] on_ticks_r, off_ticks_r;
  logic [RW-1:0]      lat_idx, wr_idx;
  logic [CW-1:0]      wr_col;
  logic               is_tick, tick, exec, first_col, last_col;

  // Command issue: a tick waits for room in the result queue
  assign is_tick  = (cmd.op == CMD_TICK);
  assign cmd_pop  = cmd_valid && (!is_tick || !res_full);
  assign exec     = cmd_pop;
  assign tick     = cmd_pop && is_tick;
  assign res_push = tick;

  // Configuration registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_ticks_r  <= ON_TICKS_RST;
      off_ticks_r <= OFF_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ON_TICKS:  on_ticks_r  <= cfg_data;
        CFG_OFF_TICKS: off_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame store updates
  assign wr_idx = cmd.row_idx[RW-1:0];
  assign wr_col = CW'(cmd.col_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) begin
        green_plane_r[i] <= '0;
        red_plane_r[i]   <= '0;
      end
    end else if (exec && cmd.op == CMD_CLEAR) begin
      for (int i = 0; i < ROWS; i++) begin
        green_plane_r[i] <= '0;
        red_plane_r[i]   <= '0;
      end
    end else if (exec && cmd.op == CMD_WRITE) begin
      unique case (cmd.color)
        COLOR_GREEN: green_plane_r[wr_idx][wr_col] <= 1'b1;
        COLOR_RED:   red_plane_r[wr_idx][wr_col]   <= 1'b1;
        COLOR_ORANGE: begin
          green_plane_r[wr_idx][wr_col] <= 1'b1;
          red_plane_r[wr_idx][wr_col]   <= 1'b1;
        end
        COLOR_BLANK: begin
          green_plane_r[wr_idx][wr_col] <= 1'b0;
          red_plane_r[wr_idx][wr_col]   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Row being scanned, read straight from the store on its first column
  assign lat_idx   = RW'(cur_row_r - RSEL_W'(1));
  assign green_row = green_plane_r[lat_idx];
  assign red_row   = red_plane_r[lat_idx];
  assign first_col = (col_cnt_r == '0);
  assign last_col  = (col_cnt_r == CW'(COLUMNS - 1));
  assign dwell_inc = dwell_r + TICKS_W'(1);
  assign row_wrap  = (cur_row_r >= RSEL_W'(ROWS)) ? RSEL_W'(1) : cur_row_r + RSEL_W'(1);

  // Scanner next state
  always_comb begin
    phase_nxt      = phase_r;
    col_cnt_nxt    = col_cnt_r;
    dwell_nxt      = dwell_r;
    cur_row_nxt    = cur_row_r;
    green_line_nxt = green_line_r;
    red_line_nxt   = red_line_r;
    if (tick) begin
      unique case (phase_r)
        PH_SHIFT: begin
          // shift line: bit 0 is the next column out
          if (first_col) begin
            green_line_nxt = green_row >> 1;
            red_line_nxt   = red_row >> 1;
          end else begin
            green_line_nxt = green_line_r >> 1;
            red_line_nxt   = red_line_r >> 1;
          end
          if (last_col) begin
            col_cnt_nxt = '0;
            dwell_nxt   = '0;
            phase_nxt   = PH_ON;
          end else begin
            col_cnt_nxt = col_cnt_r + CW'(1);
          end
        end
        PH_ON: begin
          if (dwell_inc >= on_ticks_r) begin
            dwell_nxt = '0;
            if (off_ticks_r == '0) begin
              col_cnt_nxt = '0;
              phase_nxt   = PH_SHIFT;
              cur_row_nxt = row_wrap;
            end else begin
              phase_nxt = PH_OFF;
            end
          end else begin
            dwell_nxt = dwell_inc;
          end
        end
        PH_OFF: begin
          if (dwell_inc >= off_ticks_r) begin
            dwell_nxt   = '0;
            col_cnt_nxt = '0;
            phase_nxt   = PH_SHIFT;
            cur_row_nxt = row_wrap;
          end else begin
            dwell_nxt = dwell_inc;
          end
        end
        default: phase_nxt = PH_SHIFT;
      endcase
    end
  end

  // Result fields for this tick
  always_comb begin
    res = '0;
    unique case (phase_r)
      PH_SHIFT: begin
        res.green_data  = first_col ? green_row[0] : green_line_r[0];
        res.red_data    = first_col ? red_row[0] : red_line_r[0];
        res.shift_clock = 1'b1;
      end
      PH_ON:   res.row_select = cur_row_r;
      PH_OFF:  res.row_select = '0;
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SHIFT;
      col_cnt_r <= '0;
      dwell_r   <= '0;
      cur_row_r <= RSEL_W'(1);
    end else begin
      phase_r   <= phase_nxt;
      col_cnt_r <= col_cnt_nxt;
      dwell_r   <= dwell_nxt;
      cur_row_r <= cur_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    green_line_r <= green_line_nxt;
    red_line_r   <= red_line_nxt;
  end

endmodule
`default_nettype wire

@@ src/lmsd_resq.sv @@
// Result queue between the back end and the output ports.
`timescale 1ns / 1ps
`default_nettype none
module lmsd_resq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          res_push,
  input  wire lmsd_pkg::res_t                res,
  output logic                               res_full,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic                               out_green_data,
  output logic                               out_red_data,
  output logic                               out_shift_clock,
  output logic [lmsd_pkg::RSEL_W-1:0]        out_row_select
);
  import lmsd_pkg::*;

  localparam int PW = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
  localparam int NW = $clog2(RESQ_DEPTH + 1);

  res_t          entry_r [RESQ_DEPTH];
  res_t          head;
  logic [PW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign res_full  = (count_r == NW'(RESQ_DEPTH));
  assign out_empty = (count_r == '0);
  assign do_push   = res_push && !res_full;
  assign do_pop    = out_pop && !out_empty;

  // Oldest item on the ports
  assign head            = entry_r[rptr_r];
  assign out_green_data  = head.green_data;
  assign out_red_data    = head.red_data;
  assign out_shift_clock = head.shift_clock;
  assign out_row_select  = head.row_select;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(RESQ_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(RESQ_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + NW'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wptr_r] <= res;
    end
  end

endmodule
`default_nettype wire

@@ src/bicolor_led_matrix_scan_driver_top.sv @@
// Top level of the bicolor LED matrix scan driver.
// Red/green LED matrix frame store (ROWS x COLUMNS per color) with a row-scan
// serial driver. Items are pushed as mode 0 (pixel write), 1 (clear both
// planes) or 2 (scan tick); only scan ticks produce a result item, which
// carries the green/red serial bits, the shift clock flag and the selected
// row. Each row takes COLUMNS shift ticks, then on_ticks ticks selected (one
// if on_ticks is 0), then off_ticks ticks dark. The block sustains one item
// per clock through the back end; a scan tick waits only while the
// two-entry result queue is full, and a two-entry command queue sits between
// the classifier and the back end. Pixel writes with out-of-range
// coordinates and mode 3 are dropped at the front. Configuration writes are
// always accepted (cfg_ready is high); indexes beyond the two timing
// registers are ignored.
`timescale 1ns / 1ps
`default_nettype none
module bicolor_led_matrix_scan_driver_top #(
  parameter int COLUMNS = lmsd_pkg::DEF_COLUMNS,
  parameter int ROWS    = lmsd_pkg::DEF_ROWS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic [lmsd_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [lmsd_pkg::PCOL_W-1:0]    in_pixel_column,
  input  wire logic [lmsd_pkg::PROW_W-1:0]    in_pixel_row,
  input  wire logic [lmsd_pkg::COLOR_W-1:0]   in_pixel_color,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic                                out_green_data,
  output logic                                out_red_data,
  output logic                                out_shift_clock,
  output logic [lmsd_pkg::RSEL_W-1:0]         out_row_select,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lmsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lmsd_pkg::TICKS_W-1:0]   cfg_data
);
  import lmsd_pkg::*;

  cmd_t cmd;
  res_t res;
  logic cmd_valid, cmd_pop;
  logic res_push, res_full;

  // Classifier and command queue
  lmsd_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_mode        (in_mode),
    .in_pixel_column(in_pixel_column),
    .in_pixel_row   (in_pixel_row),
    .in_pixel_color (in_pixel_color),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  // Frame store and scanner
  lmsd_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full)
  );

  // Result queue
  lmsd_resq u_resq (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_push       (res_push),
    .res            (res),
    .res_full       (res_full),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_green_data (out_green_data),
    .out_red_data   (out_red_data),
    .out_shift_clock(out_shift_clock),
    .out_row_select (out_row_select)
  );

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Testbench for the bicolor LED matrix scan driver: random and directed items.
`timescale 1ns / 1ps
module tb;
  import lmsd_pkg::*;

  localparam int NCOLS = DEF_COLUMNS;
  localparam int NROWS = DEF_ROWS;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  // indexes past the two timing registers, ignored by the block
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 4'd15;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 200;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [PCOL_W-1:0]  col;
    logic [PROW_W-1:0]  row;
    logic [COLOR_W-1:0] color;
  } scan_item_t;

  // DUT ports, inputs all known from time zero
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [MODE_W-1:0] in_mode = '0;
  logic [PCOL_W-1:0] in_pixel_column = '0;
  logic [PROW_W-1:0] in_pixel_row = '0;
  logic [COLOR_W-1:0] in_pixel_color = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_green_data;
  logic out_red_data;
  logic out_shift_clock;
  logic [RSEL_W-1:0] out_row_select;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICKS_W-1:0] cfg_data = '0;

  // testbench state
  scan_item_t pending_items[$];
  res_t expected_scan[$];
  scan_item_t cur_item;
  int accepted_count = 0;
  int err_count = 0;
  int send_wait = 0;
  int pop_wait = 0;
  bit idle_on = 1'b1;
  logic hold_pop = 1'b0;

  // predictor copy of the block
  logic [NCOLS-1:0] grn_store [NROWS];
  logic [NCOLS-1:0] red_store [NROWS];
  logic [NCOLS-1:0] grn_shift;
  logic [NCOLS-1:0] red_shift;
  scan_phase_t scan_ph;
  int col_cnt;
  int cur_row;
  int dwell;
  logic [TICKS_W-1:0] on_cfg;
  logic [TICKS_W-1:0] off_cfg;

  bicolor_led_matrix_scan_driver_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_mode(in_mode),
    .in_pixel_column(in_pixel_column),
    .in_pixel_row(in_pixel_row),
    .in_pixel_color(in_pixel_color),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_green_data(out_green_data),
    .out_red_data(out_red_data),
    .out_shift_clock(out_shift_clock),
    .out_row_select(out_row_select),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int draw_idle();
    if (!idle_on) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  task automatic reset_scan_model();
    for (int i = 0; i < NROWS; i++) begin
      grn_store[i] = '0;
      red_store[i] = '0;
    end
    grn_shift = '0;
    red_shift = '0;
    scan_ph = PH_SHIFT;
    col_cnt = 0;
    cur_row = 1;
    dwell = 0;
    on_cfg = ON_TICKS_RST;
    off_cfg = OFF_TICKS_RST;
  endtask

  task automatic advance_row();
    dwell = 0;
    col_cnt = 0;
    scan_ph = PH_SHIFT;
    cur_row = (cur_row >= NROWS) ? 1 : cur_row + 1;
  endtask

  // Update the store or scanner for one accepted item; ticks queue a result.
  task automatic predict_scan(input scan_item_t it);
    res_t res;
    int x;
    int r;
    res = '0;
    case (it.mode)
      MODE_PIXEL: begin
        if (it.col >= 1 && it.col <= NCOLS && it.row >= 1 && it.row <= NROWS) begin
          x = int'(it.col) - 1;
          r = NROWS - int'(it.row);
          case (it.color)
            COLOR_GREEN: grn_store[r][x] = 1'b1;
            COLOR_RED: red_store[r][x] = 1'b1;
            COLOR_ORANGE: begin
              grn_store[r][x] = 1'b1;
              red_store[r][x] = 1'b1;
            end
            default: begin
              grn_store[r][x] = 1'b0;
              red_store[r][x] = 1'b0;
            end
          endcase
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < NROWS; i++) begin
          grn_store[i] = '0;
          red_store[i] = '0;
        end
      end
      MODE_TICK: begin
        if (scan_ph == PH_ON) begin
          res.row_select = RSEL_W'(cur_row);
          dwell++;
          // an on time of zero still selects the row for one tick
          if (dwell >= on_cfg) begin
            dwell = 0;
            if (off_cfg == 0) advance_row();
            else scan_ph = PH_OFF;
          end
        end else if (scan_ph == PH_OFF) begin
          dwell++;
          if (dwell >= off_cfg) advance_row();
        end else begin
          // row is latched at its first shift tick
          if (col_cnt == 0) begin
            grn_shift = grn_store[cur_row - 1];
            red_shift = red_store[cur_row - 1];
          end
          res.green_data = grn_shift[col_cnt];
          res.red_data = red_shift[col_cnt];
          res.shift_clock = 1'b1;
          col_cnt++;
          if (col_cnt >= NCOLS) begin
            col_cnt = 0;
            dwell = 0;
            scan_ph = PH_ON;
          end
        end
        expected_scan.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Driver: one item at a time from the pending queue, with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      send_wait <= 0;
    end else if (!(in_push && in_full)) begin
      if (in_push) begin
        predict_scan(cur_item);
        accepted_count++;
      end
      if (send_wait > 0) begin
        send_wait <= send_wait - 1;
        in_push <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        in_mode <= cur_item.mode;
        in_pixel_column <= cur_item.col;
        in_pixel_row <= cur_item.row;
        in_pixel_color <= cur_item.color;
        in_push <= 1'b1;
        send_wait <= draw_idle();
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Monitor: pop results with random stalls and compare against predictions
  always @(posedge clk) begin : monitor
    res_t exp_res;
    res_t got;
    int w;
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_wait <= 0;
    end else begin
      w = pop_wait;
      if (out_pop && !out_empty) begin
        got.green_data = out_green_data;
        got.red_data = out_red_data;
        got.shift_clock = out_shift_clock;
        got.row_select = out_row_select;
        if (expected_scan.size() == 0) begin
          if (err_count < MAX_REPORTS)
            $display("tb: unexpected result at %0t: g=%0b r=%0b clk=%0b sel=%0d", $time,
                     got.green_data, got.red_data, got.shift_clock, got.row_select);
          err_count++;
        end else begin
          exp_res = expected_scan.pop_front();
          if (got.green_data !== exp_res.green_data || got.red_data !== exp_res.red_data ||
              got.shift_clock !== exp_res.shift_clock ||
              got.row_select !== exp_res.row_select) begin
            if (err_count < MAX_REPORTS)
              $display("tb: mismatch at %0t: exp g%0b r%0b c%0b s%0d, got g%0b r%0b c%0b s%0d",
                       $time, exp_res.green_data, exp_res.red_data, exp_res.shift_clock,
                       exp_res.row_select, got.green_data, got.red_data, got.shift_clock,
                       got.row_select);
            err_count++;
          end
        end
        w = draw_idle();
      end
      if (w > 0) begin
        pop_wait <= w - 1;
        out_pop <= 1'b0;
      end else begin
        pop_wait <= 0;
        out_pop <= !hold_pop;
      end
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (accepted_count >= 450);
    @(posedge clk);
    hold_pop <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_pop <= 1'b0;
  end

  // Run limit
  initial begin
    #5ms;
    $display("tb: done, errors");
    $finish;
  end

  task automatic queue_item(input logic [MODE_W-1:0] m, input int c, input int r,
                            input int k);
    scan_item_t it;
    it.mode = m;
    it.col = PCOL_W'(c);
    it.row = PROW_W'(r);
    it.color = COLOR_W'(k);
    pending_items.push_back(it);
  endtask

  // Mostly ticks and in-range writes, with out-of-range writes, clears and unused mode
  task automatic queue_random(input int n, input int tick_pct);
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < tick_pct) begin
        queue_item(MODE_TICK, $urandom_range(0, 127), $urandom_range(0, 15),
                   $urandom_range(0, 3));
      end else begin
        p = $urandom_range(0, 99);
        if (p < 85)
          queue_item(MODE_PIXEL, $urandom_range(1, NCOLS), $urandom_range(1, NROWS),
                     $urandom_range(0, 3));
        else if (p < 95)
          queue_item(MODE_PIXEL, $urandom_range(0, 127), $urandom_range(0, 15),
                     $urandom_range(0, 3));
        else if (p < 97)
          queue_item(MODE_CLEAR, $urandom_range(0, 127), $urandom_range(0, 15),
                     $urandom_range(0, 3));
        else
          queue_item(MODE_UNUSED, $urandom_range(0, 127), $urandom_range(0, 15),
                     $urandom_range(0, 3));
      end
    end
  endtask

  // Wait for all items taken and all results seen, then let the pipeline settle;
  // sampled at the falling edge so the driver's updates have all landed
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_push || expected_scan.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICKS_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ON_TICKS) on_cfg = val;
    else if (idx == CFG_OFF_TICKS) off_cfg = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int n, input int tick_pct, input bit with_idle);
    @(negedge clk);
    idle_on = with_idle;
    queue_random(n, tick_pct);
    drain();
  endtask

  // Stimulus sequence
  initial begin
    reset_scan_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: color codes, edge columns, out-of-range coordinates, unused mode
    queue_item(MODE_CLEAR, 0, 0, 0);
    queue_item(MODE_PIXEL, 1, 7, COLOR_GREEN);
    queue_item(MODE_PIXEL, NCOLS, 7, COLOR_RED);
    queue_item(MODE_PIXEL, 2, 7, COLOR_ORANGE);
    queue_item(MODE_PIXEL, 3, 7, COLOR_GREEN);
    queue_item(MODE_PIXEL, 3, 7, COLOR_BLANK);
    queue_item(MODE_PIXEL, 4, 7, COLOR_RED);
    queue_item(MODE_PIXEL, 0, 7, COLOR_GREEN);
    queue_item(MODE_PIXEL, NCOLS + 1, 1, COLOR_RED);
    queue_item(MODE_PIXEL, 5, 0, COLOR_ORANGE);
    queue_item(MODE_PIXEL, 5, 8, COLOR_GREEN);
    queue_item(MODE_PIXEL, 127, 15, COLOR_BLANK);
    queue_item(MODE_PIXEL, NCOLS, 1, COLOR_ORANGE);
    queue_item(MODE_UNUSED, 1, 7, COLOR_GREEN);
    for (int i = 0; i < 10; i++)
      queue_item(MODE_TICK, 0, 0, 0);
    // write into the row being shifted: must show only on its next scan
    queue_item(MODE_PIXEL, 6, 7, COLOR_RED);
    queue_random(280, 60);
    drain();

    // minimal on time, no off time, no idling
    write_reg(CFG_ON_TICKS, 16'd1);
    write_reg(CFG_OFF_TICKS, 16'd0);
    run_phase(280, 65, 1'b0);

    // zero on time, one off tick; spare indexes must be ignored
    write_reg(CFG_ON_TICKS, 16'd0);
    write_reg(CFG_OFF_TICKS, 16'd1);
    write_reg(CFG_SPARE_LO, 16'h5555);
    write_reg(CFG_SPARE_HI, 16'hAAAA);
    run_phase(230, 60, 1'b1);

    write_reg(CFG_ON_TICKS, 16'd3);
    write_reg(CFG_OFF_TICKS, 16'd7);
    run_phase(230, 60, 1'b1);

    // largest on and off times, tick-heavy so the scan sits in a long on phase
    write_reg(CFG_ON_TICKS, 16'hFFFF);
    write_reg(CFG_OFF_TICKS, 16'hFFFF);
    run_phase(150, 90, 1'b0);

    write_reg(CFG_ON_TICKS, 16'd2);
    write_reg(CFG_OFF_TICKS, 16'd0);
    run_phase(180, 60, 1'b1);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_scan.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
